>>> sv/kumst_pkg.sv
`timescale 1ns / 1ps

package kumst_pkg;

    localparam int VTX_W   = 10;
    localparam int WGT_W   = 16;
    localparam int CFG_W   = 11;
    localparam int CNT_W   = 10;
    localparam int SUM_W   = 27;
    localparam int RANK_W  = 4;

    localparam logic [CFG_W-1:0]  VTX_RESET = CFG_W'(1024);
    localparam logic [RANK_W-1:0] RANK_MAX  = '1;
    localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX   = '1;

    localparam logic OP_EDGE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef struct packed {
        logic             op;
        logic [VTX_W-1:0] first_vertex;
        logic [VTX_W-1:0] second_vertex;
        logic [WGT_W-1:0] edge_weight;
    } t_in_item;

    typedef struct packed {
        logic             taken;
        logic [CNT_W-1:0] edges_so_far;
        logic [SUM_W-1:0] tree_weight;
        logic             complete;
    } t_out_item;

    // sequencer -> tally controls
    typedef struct packed {
        logic clear;
        logic take;
        logic check;
    } t_tally_cmd;

endpackage

>>> sv/kumst_tally.sv
`timescale 1ns / 1ps

// Edge count, saturating weight sum and completion flag.
module kumst_tally import kumst_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_tally_cmd       i_cmd,
    input  logic [WGT_W-1:0] i_weight,
    input  logic [CFG_W-1:0] i_vtx_n,
    output logic [CNT_W-1:0] o_count,
    output logic [SUM_W-1:0] o_sum,
    output logic             o_finished
);

    logic [CNT_W-1:0] r_count, n_count;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic             r_finished, n_finished;
    logic [SUM_W:0]   sum_ext;

    always_comb begin
        n_count    = r_count;
        n_sum      = r_sum;
        n_finished = r_finished;
        sum_ext    = {1'b0, r_sum} + (SUM_W+1)'(i_weight);
        if (i_cmd.clear) begin
            n_count    = '0;
            n_sum      = '0;
            n_finished = 1'b0;
        end else if (i_cmd.take) begin
            if (r_count != COUNT_MAX) begin
                n_count = r_count + CNT_W'(1);
            end
            n_sum = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
        end else if (i_cmd.check) begin
            // vertex count is at least one here
            if ({1'b0, r_count} >= (i_vtx_n - CFG_W'(1))) begin
                n_finished = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_sum      <= '0;
            r_finished <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_sum      <= n_sum;
            r_finished <= n_finished;
        end
    end

    assign o_count    = r_count;
    assign o_sum      = r_sum;
    assign o_finished = r_finished;

endmodule

>>> sv/kruskal_union_find_mst_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// --------  ---------  -------------------  ------------------------------------
// in        input      i_in_valid/o_in_stall   t_in_item: op, vertices, weight
// out       output     o_out_valid/i_out_stall t_out_item: taken, count, sum, done
// cfg       input      i_cfg_valid/o_cfg_ready vertex count (11 bits)
//
// One transaction at a time. An accepted edge runs, for each endpoint in turn, a find walk
// up the parent table to the root and then a path compression walk, both on the single
// table read port; join, check and emit follow in that order.
// The result is registered and becomes valid in the same cycle as the input is ready again.
// Skipped edges (done, out of range) go straight to check and emit; a restart reruns the clearing pass, then emits.
// After reset a clearing pass over all MAX_VERTICES table entries runs with o_in_stall high.
// Configuration is always accepted. A stalled result is held while the next edge runs.
module kruskal_union_find_mst_unit import kumst_pkg::*; #(
    parameter int MAX_VERTICES = 1024,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int MAX_N = (MAX_VERTICES > 2047) ? 2047 : MAX_VERTICES;
    localparam int WM_B  = (WEIGHT_BITS < WGT_W) ? WEIGHT_BITS : WGT_W;
    localparam logic [WGT_W-1:0] W_MASK    = WGT_W'((64'd1 << WM_B) - 64'd1);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(MAX_VERTICES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,    // sweep tables to identity / rank zero
        S_IDLE,
        S_FIND,     // walk up to the root
        S_COMP,     // path compression walk
        S_JOIN,
        S_CHECK,
        S_EMIT
    } t_state;

    // ---------------- registers ----------------
    t_state           r_state, n_state;
    logic             r_side, n_side;          // 0: first vertex, 1: second
    logic [AW-1:0]    r_cur, n_cur;
    logic [AW-1:0]    r_u, n_u, r_v, n_v;
    logic [AW-1:0]    r_ru, n_ru, r_rv, n_rv;
    logic [RANK_W-1:0] r_rk_u, n_rk_u, r_rk_v, n_rk_v;
    logic [WGT_W-1:0] r_w, n_w;
    logic             r_took, n_took;
    logic [AW-1:0]    r_clr, n_clr;
    logic             r_emit_clr, n_emit_clr;  // restart owes a result
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;
    logic [CFG_W-1:0] r_vcount;

    // ---------------- union-find tables ----------------
    logic [AW-1:0]     r_par_mem  [MAX_VERTICES];
    logic [RANK_W-1:0] r_rank_mem [MAX_VERTICES];
    logic [AW-1:0]     r_par_q;
    logic [RANK_W-1:0] r_rank_q;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              par_we;
    logic [AW-1:0]     par_wa, par_wd;
    logic              rank_we;
    logic [AW-1:0]     rank_wa;
    logic [RANK_W-1:0] rank_wd;

    // ---------------- tally ----------------
    t_tally_cmd        tally_cmd;
    logic [CNT_W-1:0]  cnt;
    logic [SUM_W-1:0]  sum;
    logic              finished;

    logic [CFG_W-1:0]  vtx_n;
    logic              in_acc;
    logic              in_range;
    logic [AW-1:0]     root_sel, start_sel;

    // effective vertex count: zero reads as one, clipped to the table size
    always_comb begin
        if (r_vcount == '0) begin
            vtx_n = CFG_W'(1);
        end else if (r_vcount > CFG_W'(MAX_N)) begin
            vtx_n = CFG_W'(MAX_N);
        end else begin
            vtx_n = r_vcount;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_range    = ({1'b0, i_in_data.first_vertex} < vtx_n)
                      && ({1'b0, i_in_data.second_vertex} < vtx_n);
    assign root_sel    = r_side ? r_rv : r_ru;
    assign start_sel   = r_side ? r_v : r_u;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_side      = r_side;
        n_cur       = r_cur;
        n_u         = r_u;
        n_v         = r_v;
        n_ru        = r_ru;
        n_rv        = r_rv;
        n_rk_u      = r_rk_u;
        n_rk_v      = r_rk_v;
        n_w         = r_w;
        n_took      = r_took;
        n_clr       = r_clr;
        n_emit_clr  = r_emit_clr;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        rd_en   = 1'b0;
        rd_addr = r_cur;
        par_we  = 1'b0;
        par_wa  = r_cur;
        par_wd  = root_sel;
        rank_we = 1'b0;
        rank_wa = r_ru;
        rank_wd = r_rk_u;

        tally_cmd = '0;

        unique case (r_state)
            S_CLEAR: begin
                par_we  = 1'b1;
                par_wa  = r_clr;
                par_wd  = r_clr;
                rank_we = 1'b1;
                rank_wa = r_clr;
                rank_wd = '0;
                if (r_clr == LAST_ADDR) begin
                    n_clr           = '0;
                    n_took          = 1'b0;
                    tally_cmd.clear = 1'b1;
                    n_state         = r_emit_clr ? S_EMIT : S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end

            S_IDLE: begin
                if (in_acc) begin
                    n_u    = AW'(i_in_data.first_vertex);
                    n_v    = AW'(i_in_data.second_vertex);
                    n_w    = i_in_data.edge_weight & W_MASK;
                    n_took = 1'b0;
                    if (i_in_data.op == OP_RESTART) begin
                        n_clr      = '0;
                        n_emit_clr = 1'b1;
                        n_state    = S_CLEAR;
                    end else if (!finished && in_range) begin
                        n_side  = 1'b0;
                        n_cur   = AW'(i_in_data.first_vertex);
                        rd_en   = 1'b1;
                        rd_addr = AW'(i_in_data.first_vertex);
                        n_state = S_FIND;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end

            S_FIND: begin
                if (r_par_q == r_cur) begin
                    // root reached; rank read alongside
                    if (r_side) begin
                        n_rv   = r_cur;
                        n_rk_v = r_rank_q;
                    end else begin
                        n_ru   = r_cur;
                        n_rk_u = r_rank_q;
                    end
                    n_cur   = start_sel;
                    rd_en   = 1'b1;
                    rd_addr = start_sel;
                    n_state = S_COMP;
                end else begin
                    n_cur   = r_par_q;
                    rd_en   = 1'b1;
                    rd_addr = r_par_q;
                end
            end

            S_COMP: begin
                if (r_cur == root_sel) begin
                    if (r_side) begin
                        n_state = S_JOIN;
                    end else begin
                        n_side  = 1'b1;
                        n_cur   = r_v;
                        rd_en   = 1'b1;
                        rd_addr = r_v;
                        n_state = S_FIND;
                    end
                end else begin
                    par_we  = 1'b1;
                    par_wa  = r_cur;
                    par_wd  = root_sel;
                    n_cur   = r_par_q;
                    rd_en   = 1'b1;
                    rd_addr = r_par_q;
                end
            end

            S_JOIN: begin
                if (r_ru != r_rv) begin
                    n_took         = 1'b1;
                    tally_cmd.take = 1'b1;
                    par_we         = 1'b1;
                    if (r_rk_u < r_rk_v) begin
                        par_wa = r_ru;
                        par_wd = r_rv;
                    end else begin
                        par_wa = r_rv;
                        par_wd = r_ru;
                        if (r_rk_u == r_rk_v && r_rk_u != RANK_MAX) begin
                            rank_we = 1'b1;
                            rank_wa = r_ru;
                            rank_wd = r_rk_u + RANK_W'(1);
                        end
                    end
                end
                n_state = S_CHECK;
            end

            S_CHECK: begin
                tally_cmd.check = 1'b1;
                n_state         = S_EMIT;
            end

            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.taken        = r_took;
                    n_out.edges_so_far = cnt;
                    n_out.tree_weight  = sum;
                    n_out.complete     = finished;
                    n_out_valid        = 1'b1;
                    n_emit_clr         = 1'b0;
                    n_state            = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_emit_clr  <= 1'b0;
            r_out_valid <= 1'b0;
            r_vcount    <= VTX_RESET;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_emit_clr  <= n_emit_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_vcount <= i_cfg_data;
            end
        end
        r_side <= n_side;
        r_cur  <= n_cur;
        r_u    <= n_u;
        r_v    <= n_v;
        r_ru   <= n_ru;
        r_rv   <= n_rv;
        r_rk_u <= n_rk_u;
        r_rk_v <= n_rk_v;
        r_w    <= n_w;
        r_took <= n_took;
        r_out  <= n_out;
    end

    // table storage: one write, one registered read per table per cycle
    always_ff @(posedge i_clk) begin
        if (par_we) begin
            r_par_mem[par_wa] <= par_wd;
        end
        if (rd_en) begin
            r_par_q <= r_par_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rank_we) begin
            r_rank_mem[rank_wa] <= rank_wd;
        end
        if (rd_en) begin
            r_rank_q <= r_rank_mem[rd_addr];
        end
    end

    kumst_tally u_tally (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (tally_cmd),
        .i_weight   (r_w),
        .i_vtx_n    (vtx_n),
        .o_count    (cnt),
        .o_sum      (sum),
        .o_finished (finished)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> sv/kumst_checker.sv
`timescale 1ns / 1ps

module kumst_checker import kumst_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // one transaction in flight: stalled right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while previous edge in progress");

    a_taken_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.taken) |-> (o_out_data.edges_so_far != '0))
        else $error("taken edge with zero edge count");

    a_empty_tree_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.edges_so_far == '0) |-> (o_out_data.tree_weight == '0))
        else $error("weight sum without any taken edge");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind kruskal_union_find_mst_unit kumst_checker u_kumst_checker (.*);
